// ===== hdl/cfs_pkg.sv =====
// cfs_pkg: operation and status codes and the token control struct
// shared by the search fifo cells and the top level; no dependencies
`default_nettype none

package cfs_pkg;

    // operation codes carried by an input beat
    localparam logic [1:0] OP_ENQ    = 2'd0;
    localparam logic [1:0] OP_DEQ    = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    // status codes carried by a result beat
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    // control half of the token that walks the cell chain
    typedef struct packed {
        logic       valid;
        logic [1:0] op;
        logic       empty;
        logic       full;
        logic       found;
    } tok_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/cfs_cell.sv =====
// cfs_cell: one slot of the search fifo plus one stage of the token chain
// depends on cfs_pkg for operation codes and the token control struct
`default_nettype none

module cfs_cell #(
    parameter int DEPTH = 8,
    parameter int SW    = 32,
    parameter int IDX   = 0
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    hold,
    input  wire [$clog2(DEPTH)-1:0] head,
    input  wire [$clog2(DEPTH)-1:0] tail,
    input  wire [$clog2(DEPTH)-1:0] cnt,
    input  cfs_pkg::tok_ctl_t      ctl_in,
    input  wire [SW-1:0]           key_in,
    input  wire [SW-1:0]           data_in,
    input  wire [$clog2(DEPTH)-1:0] pos_in,
    output cfs_pkg::tok_ctl_t      ctl_out,
    output logic [SW-1:0]          key_out,
    output logic [SW-1:0]          data_out,
    output logic [$clog2(DEPTH)-1:0] pos_out
);

    localparam int IW = $clog2(DEPTH);
    localparam logic [IW:0] IDX_W   = (IW+1)'(IDX);
    localparam logic [IW:0] DEPTH_W = (IW+1)'(DEPTH);

    logic [SW-1:0]     slot_reg;
    logic [SW-1:0]     slot_next;
    cfs_pkg::tok_ctl_t ctl_reg;
    cfs_pkg::tok_ctl_t ctl_next;
    logic [SW-1:0]     key_reg;
    logic [SW-1:0]     data_reg;
    logic [SW-1:0]     data_next;
    logic [IW-1:0]     pos_reg;
    logic [IW-1:0]     pos_next;

    logic [IW:0] head_w;
    logic [IW:0] dist_w;
    logic        in_range;
    logic        wr_en;
    logic        pick;
    logic        hit;

    // distance of this slot from the head, modulo depth
    assign head_w   = {1'b0, head};
    assign dist_w   = (IDX_W >= head_w) ? (IDX_W - head_w) : (IDX_W + DEPTH_W - head_w);
    assign in_range = dist_w < {1'b0, cnt};

    // enqueue writes the tail slot as the token passes
    assign wr_en = ctl_in.valid && (ctl_in.op == cfs_pkg::OP_ENQ) && !ctl_in.full
                   && (IDX_W[IW-1:0] == tail);

    // dequeue picks the head slot, or physical slot zero when empty
    assign pick = ctl_in.valid && (ctl_in.op == cfs_pkg::OP_DEQ)
                  && ((ctl_in.empty && (IDX == 0))
                      || (!ctl_in.empty && (IDX_W[IW-1:0] == head)));

    // search keeps the match nearest the head
    assign hit = ctl_in.valid && (ctl_in.op == cfs_pkg::OP_SEARCH) && in_range
                 && (slot_reg == key_in)
                 && (!ctl_in.found || (dist_w[IW-1:0] < pos_in));

    always_comb
    begin
        slot_next = wr_en ? key_in : slot_reg;
        ctl_next  = ctl_in;
        if (hit)
        begin
            ctl_next.found = 1'b1;
        end
        data_next = pick ? slot_reg : data_in;
        pos_next  = hit ? dist_w[IW-1:0] : pos_in;
    end

    // slot storage, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
        end
        else
        begin
            slot_reg <= slot_next;
        end
    end

    // token control stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (!hold)
        begin
            ctl_reg <= ctl_next;
        end
    end

    // token payload stage
    always_ff @(posedge clk)
    begin
        if (!hold)
        begin
            key_reg  <= key_in;
            data_reg <= data_next;
            pos_reg  <= pos_next;
        end
    end

    assign ctl_out  = ctl_reg;
    assign key_out  = key_reg;
    assign data_out = data_reg;
    assign pos_out  = pos_reg;

endmodule

`default_nettype wire

// ===== hdl/circular_fifo_with_search_top.sv =====
// circular_fifo_with_search_top: pointer control, cell chain and result register
// depends on cfs_pkg and cfs_cell
`default_nettype none

// Circular fifo of DEPTH slots holding up to DEPTH-1 words, with enqueue,
// dequeue and search-by-value. Each slot lives in its own cell; an accepted
// command beat becomes a token that walks the row of cells one cell per cycle,
// writing the tail slot, picking the head slot or comparing every held slot
// against the key on the way. One command is in flight at a time: the token
// passes through the DEPTH cell stages, then the result register is loaded,
// and only then can the next command be accepted. Head and tail move when
// the token leaves the chain. A result beat held by res_stall parks the token
// in the last cell until the result register is free; cmd_stall is high while
// a command is in flight.
module circular_fifo_with_search_top #(
    parameter int DEPTH     = 8,
    parameter int WORD_BITS = 32
) (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        cmd_valid,
    output logic       cmd_stall,
    input  wire [1:0]  op,
    input  wire [31:0] value,
    output logic       res_valid,
    input  wire        res_stall,
    output logic [1:0]  status,
    output logic [31:0] data,
    output logic [2:0]  position,
    output logic [2:0]  count
);

    localparam int IW = $clog2(DEPTH);
    localparam int SW = (WORD_BITS < 32) ? WORD_BITS : 32;
    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

    logic [IW-1:0] head_reg;
    logic [IW-1:0] head_next;
    logic [IW-1:0] tail_reg;
    logic [IW-1:0] tail_next;
    logic          busy_reg;
    logic          busy_next;
    logic          res_valid_reg;
    logic          res_valid_next;
    logic [1:0]    status_reg;
    logic [31:0]   data_reg;
    logic [2:0]    position_reg;
    logic [2:0]    count_reg;

    logic [IW-1:0] head_inc;
    logic [IW-1:0] tail_inc;
    logic [IW:0]   cnt_w;
    logic [IW-1:0] cnt_cur;
    logic [IW-1:0] cnt_after;
    logic          empty;
    logic          full;
    logic          accept;
    logic          res_free;
    logic          done;
    logic          last_hold;

    logic [1:0]    status_c;
    logic [SW-1:0] data_c;
    logic [IW-1:0] pos_c;
    logic [SW+31:0] data_ext;
    logic [IW+2:0]  pos_ext;
    logic [IW+2:0]  cnt_ext;

    cfs_pkg::tok_ctl_t ctl_chain  [0:DEPTH];
    logic [SW-1:0]     key_chain  [0:DEPTH];
    logic [SW-1:0]     data_chain [0:DEPTH];
    logic [IW-1:0]     pos_chain  [0:DEPTH];
    logic [DEPTH-1:0]  tok_valid;

    // pointer arithmetic
    assign head_inc = (head_reg == LAST_IDX) ? '0 : head_reg + IW'(1);
    assign tail_inc = (tail_reg == LAST_IDX) ? '0 : tail_reg + IW'(1);
    assign cnt_w    = ({1'b0, tail_reg} >= {1'b0, head_reg})
                      ? ({1'b0, tail_reg} - {1'b0, head_reg})
                      : ({1'b0, tail_reg} + (IW+1)'(DEPTH) - {1'b0, head_reg});
    assign cnt_cur  = cnt_w[IW-1:0];
    assign empty    = (tail_reg == head_reg);
    assign full     = (tail_inc == head_reg);

    // command handshake
    assign cmd_stall = busy_reg;
    assign accept    = cmd_valid && !busy_reg;

    // token launch into the first cell
    assign ctl_chain[0] = '{valid: accept, op: op, empty: empty, full: full, found: 1'b0};
    assign key_chain[0]  = value[SW-1:0];
    assign data_chain[0] = '0;
    assign pos_chain[0]  = '0;

    // the last cell parks its token while the result register is taken
    assign res_free  = !res_valid_reg || !res_stall;
    assign done      = ctl_chain[DEPTH].valid && res_free;
    assign last_hold = ctl_chain[DEPTH].valid && !res_free;

    // row of cells
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        cfs_cell #(
            .DEPTH (DEPTH),
            .SW    (SW),
            .IDX   (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .hold     ((i == DEPTH - 1) ? last_hold : 1'b0),
            .head     (head_reg),
            .tail     (tail_reg),
            .cnt      (cnt_cur),
            .ctl_in   (ctl_chain[i]),
            .key_in   (key_chain[i]),
            .data_in  (data_chain[i]),
            .pos_in   (pos_chain[i]),
            .ctl_out  (ctl_chain[i+1]),
            .key_out  (key_chain[i+1]),
            .data_out (data_chain[i+1]),
            .pos_out  (pos_chain[i+1])
        );
        assign tok_valid[i] = ctl_chain[i+1].valid;
    end

    // result of the token leaving the chain
    always_comb
    begin
        status_c  = cfs_pkg::ST_OK;
        data_c    = '0;
        pos_c     = '0;
        cnt_after = cnt_cur;
        head_next = head_reg;
        tail_next = tail_reg;
        case (ctl_chain[DEPTH].op)
            cfs_pkg::OP_ENQ:
            begin
                if (ctl_chain[DEPTH].full)
                begin
                    status_c = cfs_pkg::ST_FULL;
                end
                else
                begin
                    tail_next = tail_inc;
                    cnt_after = cnt_cur + IW'(1);
                end
            end
            cfs_pkg::OP_DEQ:
            begin
                data_c = data_chain[DEPTH];
                if (ctl_chain[DEPTH].empty)
                begin
                    status_c = cfs_pkg::ST_EMPTY;
                end
                else
                begin
                    head_next = head_inc;
                    cnt_after = cnt_cur - IW'(1);
                end
            end
            cfs_pkg::OP_SEARCH:
            begin
                if (ctl_chain[DEPTH].found)
                begin
                    pos_c = pos_chain[DEPTH];
                end
                else
                begin
                    status_c = cfs_pkg::ST_NOT_FOUND;
                end
            end
            default:
            begin
                status_c = cfs_pkg::ST_OK;
            end
        endcase
        if (!done)
        begin
            head_next = head_reg;
            tail_next = tail_reg;
        end
    end

    assign data_ext = {32'd0, data_c};
    assign pos_ext  = {3'b000, pos_c};
    assign cnt_ext  = {3'b000, cnt_after};

    // control next state
    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (done)
        begin
            busy_next = 1'b0;
        end
        res_valid_next = res_valid_reg;
        if (done)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    // pointers and handshake state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            busy_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            busy_reg      <= busy_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // result beat payload
    always_ff @(posedge clk)
    begin
        if (done)
        begin
            status_reg   <= status_c;
            data_reg     <= data_ext[31:0];
            position_reg <= pos_ext[2:0];
            count_reg    <= cnt_ext[2:0];
        end
    end

    assign res_valid = res_valid_reg;
    assign status    = status_reg;
    assign data      = data_reg;
    assign position  = position_reg;
    assign count     = count_reg;

`ifndef SYNTHESIS
    // at most one token in the chain, and none while idle
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_valid) && (busy_reg || (tok_valid == '0)))
        else $error("token chain holds more than one token or a stray token");

    // an accepted beat marks the block busy
    a_busy_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg)
        else $error("busy not set after accepting a command");

    // pointers stay put while a token walks the chain
    a_ptr_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !done) |=> ($stable(head_reg) && $stable(tail_reg)))
        else $error("head or tail moved during a command");

    // a finished token yields a result beat and frees the command side
    a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (res_valid && !busy_reg))
        else $error("finished command did not produce a result beat");
`endif

endmodule

`default_nettype wire
